// ----- hw/rtl/integer_text_parser_defines.svh -----
// Assertion macros used by the integer text parser top level.
`ifndef INTEGER_TEXT_PARSER_DEFINES_SVH
`define INTEGER_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define ITP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/itp_pkg.sv -----
// Types and constants of the integer text parser.
`default_nettype none
package itp_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CHAR_BITS  = 8;

  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_BITS-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LC_F  = 8'h66;
  localparam logic [CHAR_BITS-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UC_F  = 8'h46;
  localparam logic [CHAR_BITS-1:0] CH_LC_X  = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_UC_X  = 8'h58;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_HEXPFX = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  typedef struct packed {
    phase_e phase;
    radix_e radix;
    logic   negative;
    logic   failed;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{phase: PH_START, radix: RADIX_DEC,
                                   negative: 1'b0, failed: 1'b0};

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_byte;
    logic                 is_last;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         ok;
  } out_t;

endpackage
`default_nettype wire

// ----- hw/rtl/integer_text_parser.sv -----
// Top level of the integer text parser: input register, parse state, result register.
`default_nettype none
// Parses one signed integer from text streamed one byte per beat; is_last marks the
// final byte of a string. Leading whitespace, an optional sign, and decimal, octal
// (leading 0) or hex (0x / 0X) digits are taken. The magnitude saturates at the
// 32-bit maximum, or at the minimum for a negative number (the minimum itself is
// valid); overflow clears ok. After the first bad byte the rest of the string is
// ignored, and value holds the partial result. One result beat leaves for the byte
// marked last, none for the others, and the parser then starts afresh. Rate: one byte
// per clock cycle; a result waiting on out_ready_i stalls the input only once a
// further last byte reaches the parse stage. The input and result registers lie
// between an input beat and its result beat. The rate is set by the per-byte
// shift-add and overflow compare between the input and parse state registers.
module integer_text_parser import itp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

`include "integer_text_parser_defines.svh"

  // input register
  logic in_valid_q;
  in_t  in_q;

  // parse state
  ctrl_t                 ctrl_q, ctrl_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;

  // result register
  logic out_valid_q;
  out_t out_q;
  out_t res;

  logic out_free;
  logic fire;

  // Hold the registered byte while its result cannot leave.
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && (!in_q.is_last || out_free);
  assign in_ready_o = !in_valid_q || fire;

  itp_step u_step (
    .ctrl_i (ctrl_q),
    .mag_i  (mag_q),
    .char_i (in_q.char_byte),
    .ctrl_o (ctrl_d),
    .mag_o  (mag_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  // Advance the parse state per byte; drop back to start after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= CTRL_RESET;
      mag_q  <= '0;
    end else if (fire) begin
      if (in_q.is_last) begin
        ctrl_q <= CTRL_RESET;
        mag_q  <= '0;
      end else begin
        ctrl_q <= ctrl_d;
        mag_q  <= mag_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_q.is_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_q.is_last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A last byte leaves a result and a clean parser behind.
  `ITP_ASSERT_NEXT(a_last_emits, fire && in_q.is_last,
                   out_valid_q && ctrl_q == CTRL_RESET && mag_q == '0,
                   "last byte did not emit a result or reset the parser")
  // A failure sticks until the string ends.
  `ITP_ASSERT_NEXT(a_fail_sticky, ctrl_q.failed && !(fire && in_q.is_last),
                   ctrl_q.failed, "failure flag cleared inside a string")
  // A stalled byte is neither lost nor altered.
  `ITP_ASSERT_NEXT(a_in_hold, in_valid_q && !fire,
                   in_valid_q && $stable(in_q), "stalled input byte changed")
  // The magnitude never exceeds the negative limit.
  `ITP_ASSERT_NOW(a_mag_range, ctrl_q.phase == PH_DIGITS,
                  mag_q <= (VALUE_BITS'(1) << (VALUE_BITS - 1)),
                  "magnitude beyond the saturation limit")

endmodule
`default_nettype wire

// ----- hw/rtl/itp_step.sv -----
// Per-byte next-state and result logic of the integer text parser.
`default_nettype none
module itp_step import itp_pkg::*; (
  input  ctrl_t                 ctrl_i,
  input  logic [VALUE_BITS-1:0] mag_i,
  input  logic [CHAR_BITS-1:0]  char_i,
  output ctrl_t                 ctrl_o,
  output logic [VALUE_BITS-1:0] mag_o,
  output out_t                  res_o
);

  localparam int unsigned W = VALUE_BITS + 5;
  localparam logic [W-1:0] NEG_LIM = W'(1) << (VALUE_BITS - 1);
  localparam logic [W-1:0] POS_LIM = NEG_LIM - W'(1);

  // {valid, value} of a hex-capable digit
  function automatic logic [4:0] digit_of(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] t;
    begin
      t = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        t = c - CH_ZERO;
        digit_of = {1'b1, t[3:0]};
      end else if (c >= CH_LC_A && c <= CH_LC_F) begin
        t = c - CH_LC_A + 8'd10;
        digit_of = {1'b1, t[3:0]};
      end else if (c >= CH_UC_A && c <= CH_UC_F) begin
        t = c - CH_UC_A + 8'd10;
        digit_of = {1'b1, t[3:0]};
      end else begin
        digit_of = 5'd0;
      end
    end
  endfunction

  logic [4:0]   dig;
  logic         dig_vld;
  logic [3:0]   dig_val;
  logic         is_space;
  logic         in_base;
  logic [W-1:0] mag_x;
  logic [W-1:0] scaled;
  logic [W-1:0] acc;
  logic [W-1:0] limit;

  assign dig     = digit_of(char_i);
  assign dig_vld = dig[4];
  assign dig_val = dig[3:0];
  assign is_space = (char_i == CH_SPACE) || (char_i >= CH_TAB && char_i <= CH_CR);
  assign mag_x   = {5'b0, mag_i};
  assign limit   = ctrl_i.negative ? NEG_LIM : POS_LIM;

  // shift-add by the base; magnitude never exceeds the limit, so no wrap
  always_comb begin
    unique case (ctrl_i.radix)
      RADIX_OCT: begin
        scaled  = mag_x << 3;
        in_base = dig_vld && (dig_val < 4'd8);
      end
      RADIX_HEX: begin
        scaled  = mag_x << 4;
        in_base = dig_vld;
      end
      default: begin
        scaled  = (mag_x << 3) + (mag_x << 1);
        in_base = dig_vld && (dig_val < 4'd10);
      end
    endcase
  end

  assign acc = scaled + {{(W-4){1'b0}}, dig_val};

  always_comb begin
    ctrl_o = ctrl_i;
    mag_o  = mag_i;
    if (!ctrl_i.failed) begin
      unique case (ctrl_i.phase)
        PH_START: begin
          if (is_space) begin
            ctrl_o.phase = PH_START;
          end else if (char_i == CH_PLUS || char_i == CH_MINUS) begin
            ctrl_o.negative = (char_i == CH_MINUS);
            ctrl_o.phase    = PH_SIGN;
          end else if (char_i == CH_ZERO) begin
            ctrl_o.phase = PH_ZERO;
          end else if (char_i >= CH_ONE && char_i <= CH_NINE) begin
            mag_o        = VALUE_BITS'(dig_val);
            ctrl_o.phase = PH_DIGITS;
          end else begin
            ctrl_o.failed = 1'b1;
          end
        end
        PH_SIGN: begin
          if (char_i == CH_ZERO) begin
            ctrl_o.phase = PH_ZERO;
          end else if (char_i >= CH_ONE && char_i <= CH_NINE) begin
            mag_o        = VALUE_BITS'(dig_val);
            ctrl_o.phase = PH_DIGITS;
          end else begin
            ctrl_o.failed = 1'b1;
          end
        end
        PH_ZERO: begin
          if (char_i >= CH_ZERO && char_i <= CH_SEVEN) begin
            ctrl_o.radix = RADIX_OCT;
            mag_o        = VALUE_BITS'(dig_val);
            ctrl_o.phase = PH_DIGITS;
          end else if (char_i == CH_LC_X || char_i == CH_UC_X) begin
            ctrl_o.radix = RADIX_HEX;
            ctrl_o.phase = PH_HEXPFX;
          end else begin
            ctrl_o.failed = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (!in_base) begin
            ctrl_o.failed = 1'b1;
          end else if (acc > limit) begin
            mag_o         = limit[VALUE_BITS-1:0];
            ctrl_o.failed = 1'b1;
          end else begin
            mag_o = acc[VALUE_BITS-1:0];
          end
        end
        PH_HEXPFX: begin
          if (dig_vld) begin
            mag_o        = VALUE_BITS'(dig_val);
            ctrl_o.phase = PH_DIGITS;
          end else begin
            ctrl_o.failed = 1'b1;
          end
        end
        default: begin
          ctrl_o.failed = 1'b1;
        end
      endcase
    end
  end

  assign res_o.value = ctrl_o.negative ? -mag_o : mag_o;
  assign res_o.ok    = !ctrl_o.failed &&
                       (ctrl_o.phase == PH_ZERO || ctrl_o.phase == PH_DIGITS);

endmodule
`default_nettype wire

// ----- tb/integer_text_parser_tb.sv -----
// Testbench for the integer text parser: random and directed strings, scoreboarded results.
`default_nettype none
module integer_text_parser_tb import itp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned HOLD_AFTER   = 25;   // results seen before the long back-pressure
  localparam int unsigned HOLD_CYCLES  = 300;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready_o;
  in_t  in_data;
  logic out_valid_o;
  logic out_ready;
  out_t out_o;

  integer_text_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_i       (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_o      (out_o)
  );

  // Bytes waiting to be offered, and parsed numbers waiting to come out.
  in_t  text_bytes[$];
  out_t parsed_numbers[$];

  int unsigned queued_count;
  int unsigned accepted_count;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  int unsigned send_gap;
  int unsigned recv_gap;
  logic        hold_done;

  // Own copy of the parse state.
  phase_e      ps_phase;
  radix_e      ps_radix;
  logic        ps_neg;
  logic        ps_failed;
  logic [63:0] ps_mag;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Most gaps are short, a few are long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int digit_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
    if (c >= CH_LC_A && c <= CH_LC_F) return int'(c) - int'(CH_LC_A) + 10;
    if (c >= CH_UC_A && c <= CH_UC_F) return int'(c) - int'(CH_UC_A) + 10;
    return -1;
  endfunction

  function automatic void reset_parse();
    ps_phase  = PH_START;
    ps_radix  = RADIX_DEC;
    ps_neg    = 1'b0;
    ps_failed = 1'b0;
    ps_mag    = '0;
  endfunction

  // Advance the parse state by one byte.
  function automatic void parse_char(logic [7:0] c);
    int          d;
    logic [63:0] base;
    logic [63:0] limit;
    logic [63:0] dv;
    d  = digit_value(c);
    dv = (d < 0) ? 64'd0 : 64'(d);
    case (ps_phase)
      PH_START: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          ps_neg   = (c == CH_MINUS);
          ps_phase = PH_SIGN;
        end else if (c == CH_ZERO) begin
          ps_phase = PH_ZERO;
        end else if (c >= CH_ONE && c <= CH_NINE) begin
          ps_mag   = dv;
          ps_phase = PH_DIGITS;
        end else begin
          ps_failed = 1'b1;
        end
      end
      PH_SIGN: begin
        if (c == CH_ZERO) begin
          ps_phase = PH_ZERO;
        end else if (c >= CH_ONE && c <= CH_NINE) begin
          ps_mag   = dv;
          ps_phase = PH_DIGITS;
        end else begin
          ps_failed = 1'b1;
        end
      end
      PH_ZERO: begin
        if (c >= CH_ZERO && c <= CH_SEVEN) begin
          ps_radix = RADIX_OCT;
          ps_mag   = dv;
          ps_phase = PH_DIGITS;
        end else if (c == CH_LC_X || c == CH_UC_X) begin
          ps_radix = RADIX_HEX;
          ps_phase = PH_HEXPFX;
        end else begin
          ps_failed = 1'b1;
        end
      end
      PH_DIGITS: begin
        base  = (ps_radix == RADIX_OCT) ? 64'd8 : (ps_radix == RADIX_HEX) ? 64'd16 : 64'd10;
        limit = ps_neg ? (64'd1 << (VALUE_BITS - 1)) : (64'd1 << (VALUE_BITS - 1)) - 64'd1;
        if (d < 0 || dv >= base) begin
          ps_failed = 1'b1;
        end else if (ps_mag > (limit - dv) / base) begin
          // Saturate and give up on the rest of the string.
          ps_mag    = limit;
          ps_failed = 1'b1;
        end else begin
          ps_mag = ps_mag * base + dv;
        end
      end
      PH_HEXPFX: begin
        if (d >= 0) begin
          ps_mag   = dv;
          ps_phase = PH_DIGITS;
        end else begin
          ps_failed = 1'b1;
        end
      end
      default: ps_failed = 1'b1;
    endcase
  endfunction

  // Work out the number due for one accepted byte, if it ends a string.
  function automatic void predict_number(in_t b);
    out_t r;
    logic [VALUE_BITS-1:0] m;
    if (!ps_failed) parse_char(b.char_byte);
    if (b.is_last) begin
      m       = ps_mag[VALUE_BITS-1:0];
      r.value = ps_neg ? -m : m;
      r.ok    = !ps_failed && (ps_phase == PH_ZERO || ps_phase == PH_DIGITS);
      parsed_numbers.push_back(r);
      reset_parse();
    end
  endfunction

  // Driver: offer the next byte whenever the beat slot is free and no gap is pending.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_number(in_data);
        accepted_count++;
      end
      if (!in_valid || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (text_bytes.size() != 0) begin
          in_data  <= text_bytes.pop_front();
          in_valid <= 1'b1;
          // While bits 8:7 of the cycle counter are zero, run with no idling at all.
          send_gap <= (cycle_count[8:7] == 2'b00) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest parsed number, and pace ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (parsed_numbers.size() == 0) begin
          $display("%0t: unexpected result, expected none got value %0d ok %0b",
                   $time, out_o.value, out_o.ok);
          error_count++;
        end else begin
          if (out_o.value !== parsed_numbers[0].value) begin
            $display("%0t: value mismatch, expected %0d got %0d",
                     $time, parsed_numbers[0].value, out_o.value);
            error_count++;
          end
          if (out_o.ok !== parsed_numbers[0].ok) begin
            $display("%0t: ok mismatch, expected %0b got %0b",
                     $time, parsed_numbers[0].ok, out_o.ok);
            error_count++;
          end
          void'(parsed_numbers.pop_front());
        end
      end
      // Hold ready low for a long stretch once, so the input side backs up.
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (cycle_count[9:8] != 2'b01 && $urandom_range(0, 4) == 0) begin
          recv_gap <= pick_gap();
        end
      end
    end
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_byte(logic [7:0] c, logic last);
    text_bytes.push_back('{char_byte: c, is_last: last});
    queued_count++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1);
  endtask

  // Well-formed number with random content, sometimes cut short or damaged.
  task automatic queue_random_number();
    string       s;
    logic [7:0]  chars[$];
    logic [7:0]  b;
    logic [63:0] mag;
    int unsigned n;
    s = "";
    repeat ($urandom_range(0, 2)) begin
      n = $urandom_range(0, 5);
      s = $sformatf("%s%c", s, (n == 0) ? CH_SPACE : CH_TAB + n - 1);
    end
    case ($urandom_range(0, 3))
      0: s = {s, "+"};
      1: s = {s, "-"};
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: mag = 64'($urandom_range(0, 999));
      5, 6:          mag = 64'($urandom);
      7:             mag = 64'h7FFF_FFFE + 64'($urandom_range(0, 4));
      8:             mag = {$urandom, $urandom} >> $urandom_range(0, 31);
      default:       mag = '0;
    endcase
    case ($urandom_range(0, 3))
      2: s = $sformatf("%s0%0o", s, mag);
      3: s = $sformatf("%s0%c%0h", s, $urandom_range(0, 1) ? CH_LC_X : CH_UC_X, mag);
      default: s = $sformatf("%s%0d", s, mag);
    endcase
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      if (b >= CH_LC_A && b <= CH_LC_F && $urandom_range(0, 1)) b = b - 8'h20;
      chars.push_back(b);
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, chars.size()) : chars.size();
    if ($urandom_range(0, 6) == 0) chars[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) queue_byte(chars[i], i == n - 1);
  endtask

  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  // Sample at the falling edge so the check sees settled counters.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (accepted_count != queued_count || parsed_numbers.size() != 0);
  endtask

  initial begin
    queued_count   = 0;
    accepted_count = 0;
    results_seen   = 0;
    error_count    = 0;
    cycle_count    = 0;
    reset_parse();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings: zero forms, limits in every base, whitespace, incomplete text,
    // digits outside the base and bytes with bit 7 set.
    queue_text("0");
    queue_text("-0");
    queue_text("2147483647");
    queue_text("-2147483648");
    queue_text("2147483648");
    queue_text("-0x80000001");
    queue_text("0X7fFFffFF");
    queue_text("017777777777");
    for (logic [7:0] c = CH_TAB; c <= CH_CR; c++) queue_byte(c, 1'b0);
    queue_text(" +9");
    queue_text(" ");
    queue_text("+");
    queue_text("0x");
    queue_text("089");
    queue_text("1a");
    queue_text("0xg");
    queue_byte(8'hB1, 1'b1);
    queue_byte(CH_ONE, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_text("x");
    wait_idle();

    // Random strings; pause halfway until every number has come out.
    while (queued_count < RANDOM_BYTES / 2) begin
      if ($urandom_range(0, 99) < 85) queue_random_number();
      else queue_noise();
    end
    wait_idle();
    while (queued_count < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 85) queue_random_number();
      else queue_noise();
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_count == 0 && parsed_numbers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
